@@ hdl/tga_pkg.sv @@
`timescale 1ns / 1ps
package tga_pkg;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SKIP   = 3'd1,
      PH_RAW    = 3'd2,
      PH_PKTHDR = 3'd3,
      PH_REPEAT = 3'd4,
      PH_RAWPKT = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   localparam logic [4:0] ST_OK          = 5'd0;
   localparam logic [4:0] ST_SHORT_HDR   = 5'd1;
   localparam logic [4:0] ST_BAD_TYPE    = 5'd2;
   localparam logic [4:0] ST_MAP_FLAG    = 5'd3;
   localparam logic [4:0] ST_ZERO_SIZE   = 5'd4;
   localparam logic [4:0] ST_TOO_LARGE   = 5'd5;
   localparam logic [4:0] ST_INTERLEAVE  = 5'd6;
   localparam logic [4:0] ST_RIGHT_LEFT  = 5'd7;
   localparam logic [4:0] ST_PAL_ORIGIN  = 5'd8;
   localparam logic [4:0] ST_PAL_EMPTY   = 5'd9;
   localparam logic [4:0] ST_INDEX_DEPTH = 5'd10;
   localparam logic [4:0] ST_ENTRY_BITS  = 5'd11;
   localparam logic [4:0] ST_GRAY_ALPHA  = 5'd12;
   localparam logic [4:0] ST_GRAY_DEPTH  = 5'd13;
   localparam logic [4:0] ST_TRUE_DEPTH  = 5'd14;
   localparam logic [4:0] ST_ALPHA_BITS  = 5'd15;
   localparam logic [4:0] ST_SHORT_SKIP  = 5'd16;
   localparam logic [4:0] ST_SHORT_RAW   = 5'd17;
   localparam logic [4:0] ST_SHORT_PKHDR = 5'd18;
   localparam logic [4:0] ST_OVERRUN     = 5'd19;
   localparam logic [4:0] ST_SHORT_REP   = 5'd20;
   localparam logic [4:0] ST_SHORT_RPKT  = 5'd21;
   localparam logic [4:0] ST_BAD_INDEX   = 5'd22;

   localparam int HEADER_LEN = 18;

   // decoded header, carried from the decoder to the walker and result
   typedef struct packed {
      logic [4:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [2:0]  channels;
      logic [7:0]  bpp;
      logic        rle;
      logic        palette;
      logic        top;
      logic [18:0] skip;
      logic [2:0]  pbytes;
      logic [15:0] pal_len;
   } hinfo_type;

endpackage

@@ hdl/tga_hdr_decode.sv @@
`timescale 1ns / 1ps
module tga_hdr_decode
   import tga_pkg::*;
#(
   parameter int CapWidth = 28
) (
   input  logic [7:0]          hdr [HEADER_LEN],
   input  logic [CapWidth-1:0] pixel_cap,
   output hinfo_type           info,
   output logic [31:0]         area
);
   logic [7:0]  map_flag, typ, base, pal_bits, desc, eb;
   logic [15:0] pal_first;
   logic [3:0]  alpha;
   logic [31:0] cap32;

   assign area  = 32'(info.width) * 32'(info.height);
   assign cap32 = 32'(pixel_cap);

   always_comb begin
      map_flag  = hdr[1];
      typ       = hdr[2];
      pal_first = {hdr[4], hdr[3]};
      pal_bits  = hdr[7];
      desc      = hdr[17];
      alpha     = desc[3:0];
      eb        = 8'((9'(pal_bits) + 9'd7) >> 3);
      info          = '0;
      info.rle      = (typ >= 8'd8);
      base          = info.rle ? typ - 8'd8 : typ;
      info.pal_len  = {hdr[6], hdr[5]};
      info.width    = {hdr[13], hdr[12]};
      info.height   = {hdr[15], hdr[14]};
      info.bpp      = hdr[16];
      info.top      = desc[5];
      info.palette  = (base == 8'd1);
      info.skip     = 19'(hdr[0]);
      // checks in priority order
      if (base != 8'd1 && base != 8'd2 && base != 8'd3) begin
         info.status = ST_BAD_TYPE;
      end else if (info.palette ? map_flag != 8'd1 : map_flag != 8'd0) begin
         info.status = ST_MAP_FLAG;
      end else if (info.width == 16'd0 || info.height == 16'd0) begin
         info.status = ST_ZERO_SIZE;
      end else if (area > cap32) begin
         info.status = ST_TOO_LARGE;
      end else if (desc[7:6] != 2'b00) begin
         info.status = ST_INTERLEAVE;
      end else if (desc[4]) begin
         info.status = ST_RIGHT_LEFT;
      end else if (info.palette) begin
         if (pal_first != 16'd0) info.status = ST_PAL_ORIGIN;
         else if (info.pal_len == 16'd0) info.status = ST_PAL_EMPTY;
         else if (info.bpp != 8'd8 && info.bpp != 8'd16) info.status = ST_INDEX_DEPTH;
         else begin
            if (pal_bits == 8'd8) info.channels = 3'd1;
            else if (pal_bits == 8'd15 || pal_bits == 8'd16 || pal_bits == 8'd24)
               info.channels = 3'd3;
            else if (pal_bits == 8'd32) info.channels = 3'd4;
            else info.status = ST_ENTRY_BITS;
            info.pbytes = info.bpp[4] ? 3'd2 : 3'd1;
            info.skip   = 19'(hdr[0]) + 19'(info.pal_len) * 19'(eb[2:0]);
         end
      end else if (base == 8'd3) begin
         if (info.bpp == 8'd16) info.status = ST_GRAY_ALPHA;
         else if (info.bpp != 8'd8) info.status = ST_GRAY_DEPTH;
         else begin
            info.channels = 3'd1;
            info.pbytes   = 3'd1;
         end
      end else begin
         if (info.bpp == 8'd15 || info.bpp == 8'd16) begin
            info.channels = 3'd3; info.pbytes = 3'd2;
         end else if (info.bpp == 8'd24) begin
            info.channels = 3'd3; info.pbytes = 3'd3;
         end else if (info.bpp == 8'd32) begin
            info.channels = 3'd4; info.pbytes = 3'd4;
         end else info.status = ST_TRUE_DEPTH;
      end
      if (info.status == ST_OK &&
          (info.channels == 3'd4 ? alpha != 4'd8 : alpha != 4'd0))
         info.status = ST_ALPHA_BITS;
   end
endmodule

@@ hdl/tga_stream_validator.sv @@
`timescale 1ns / 1ps
// A result transfer appears in the cycle after the last byte is taken.
// Throughput: one byte per cycle unless the result is stalled; the header is decoded
// combinationally from the 18 header registers; the payload walk is counter updates only.
// Reset (synchronous, active high) returns to header phase, clears errors,
// sets check_payload to 1 and empties the result register.
module tga_stream_validator
   import tga_pkg::*;
#(
   parameter int PIXEL_CAP = 250000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // status, image_width, image_height,
                                    // channel_count, pixel_depth, is_rle, is_palette,
                                    // rows_top_first, payload_offset, bytes_per_pixel,
                                    // palette_entries, zero fill
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CapW = 28;

   logic [7:0]  hdr_ff [HEADER_LEN];
   logic [4:0]  hcnt_ff, hcnt_in;
   phase_type   phase_ff, phase_in;
   logic [18:0] skip_ff, skip_in;
   logic [27:0] pix_ff, pix_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic [1:0]  bip_ff, bip_in;
   logic [7:0]  lowb_ff, lowb_in;
   logic        pend_ff, pend_in;
   logic [4:0]  err_ff, err_in;
   logic        cfg_ff;
   logic        ov_ff;
   logic [95:0] od_ff;

   hinfo_type   info;
   logic [31:0] area;
   logic        take, done, bad;
   logic [1:0]  bip_nx;
   logic [15:0] idx;
   logic [7:0]  pl;
   logic [95:0] res;

   tga_hdr_decode #(.CapWidth(CapW)) u_dec (
      .hdr(hdr_ff), .pixel_cap(CapW'(PIXEL_CAP)), .info(info), .area(area));

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, cfg_ff};
   assign req_tready = !ov_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   // config register write
   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= 1'b1;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 3'd0)
         cfg_ff <= csr_pwdata[0];
   end

   // pixel byte assembly
   always_comb begin
      bip_nx = bip_ff + 2'd1;
      done   = (bip_nx == info.pbytes[1:0]);
      idx    = (info.pbytes == 3'd1) ? {8'd0, lowb_ff} : {req_tdata, lowb_ff};
      if (bip_ff == 2'd0) idx[7:0] = req_tdata;
      bad    = info.palette && idx >= info.pal_len;
      pl     = {1'b0, req_tdata[6:0]} + 8'd1;
   end

   // next state for one byte
   always_comb begin
      hcnt_in = hcnt_ff; phase_in = phase_ff; skip_in = skip_ff; pix_in = pix_ff;
      pkt_in = pkt_ff; bip_in = bip_ff; lowb_in = lowb_ff; pend_in = pend_ff;
      err_in = err_ff;
      if (err_ff == ST_OK) begin
         unique case (phase_ff)
            PH_HEADER: begin
               hcnt_in = hcnt_ff + 5'd1;
               if (hcnt_ff == 5'(HEADER_LEN - 1)) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 19'd1;
            end
            PH_RAW, PH_REPEAT, PH_RAWPKT: begin
               if (bip_ff == 2'd0) lowb_in = req_tdata;
               bip_in = done ? 2'd0 : bip_nx;
               if (done) begin
                  if (phase_ff == PH_REPEAT) begin
                     if (bad) err_in = ST_BAD_INDEX;
                     else begin
                        pix_in   = pix_ff - 28'(pkt_ff);
                        pkt_in   = 8'd0;
                        phase_in = (pix_ff == 28'(pkt_ff)) ? PH_DONE : PH_PKTHDR;
                     end
                  end else begin
                     pend_in = pend_ff | bad;
                     pix_in  = pix_ff - 28'd1;
                     if (phase_ff == PH_RAW) begin
                        if (pix_ff == 28'd1) begin
                           if (pend_in) err_in = ST_BAD_INDEX;
                           else phase_in = PH_DONE;
                        end
                     end else begin
                        pkt_in = pkt_ff - 8'd1;
                        if (pkt_ff == 8'd1) begin
                           if (pend_in) err_in = ST_BAD_INDEX;
                           else phase_in = (pix_ff == 28'd1) ? PH_DONE : PH_PKTHDR;
                        end
                     end
                  end
               end
            end
            PH_PKTHDR: begin
               pkt_in = pl;
               if (28'(pl) > pix_ff) err_in = ST_OVERRUN;
               else begin
                  bip_in = 2'd0; pend_in = 1'b0;
                  phase_in = req_tdata[7] ? PH_REPEAT : PH_RAWPKT;
               end
            end
            default: phase_in = PH_DONE;
         endcase
      end
   end

   // decode the stored header with the incoming byte merged in, so the
   // 18th byte already sees the complete header
   logic        hdr_last;
   logic [7:0]  hdr_nx [HEADER_LEN];
   hinfo_type   info_nx;
   logic [31:0] area_nx;
   always_comb begin
      for (int i = 0; i < HEADER_LEN; i++) hdr_nx[i] = hdr_ff[i];
      if (phase_ff == PH_HEADER && hcnt_ff < 5'(HEADER_LEN))
         hdr_nx[hcnt_ff] = req_tdata;
   end
   assign hdr_last = (err_ff == ST_OK) && phase_ff == PH_HEADER
                     && hcnt_ff == 5'(HEADER_LEN - 1);
   tga_hdr_decode #(.CapWidth(CapW)) u_dec_nx (
      .hdr(hdr_nx), .pixel_cap(CapW'(PIXEL_CAP)), .info(info_nx), .area(area_nx));

   // result word fields from the decoded header
   always_comb begin
      res = '0;
      res[4:0]    = ST_OK;
      res[20:5]   = info_nx.width;
      res[36:21]  = info_nx.height;
      res[39:37]  = info_nx.channels;
      res[47:40]  = info_nx.bpp;
      res[48]     = info_nx.rle;
      res[49]     = info_nx.palette;
      res[50]     = info_nx.top;
      res[69:51]  = info_nx.skip + 19'(HEADER_LEN);
      res[72:70]  = info_nx.pbytes;
      res[88:73]  = info_nx.palette ? info_nx.pal_len : 16'd0;
   end

   // phase after header entry or skip end, folded into final next values
   phase_type   ph_f;
   logic [4:0]  err_f;
   logic [18:0] skip_f;
   logic [27:0] pix_f;
   logic [1:0]  bip_f;
   logic        pend_f;
   always_comb begin
      ph_f = phase_in; err_f = err_in; skip_f = skip_in; pix_f = pix_in;
      bip_f = bip_in; pend_f = pend_in;
      if (hdr_last) begin
         if (info_nx.status != ST_OK) err_f = info_nx.status;
         else begin
            skip_f = info_nx.skip;
            if (info_nx.skip == 19'd0) begin
               ph_f  = !cfg_ff ? PH_DONE : (info_nx.rle ? PH_PKTHDR : PH_RAW);
               pix_f = area_nx[27:0]; bip_f = 2'd0; pend_f = 1'b0;
            end else ph_f = PH_SKIP;
         end
      end else if (err_ff == ST_OK && phase_ff == PH_SKIP && skip_ff == 19'd1) begin
         ph_f  = !cfg_ff ? PH_DONE : (info.rle ? PH_PKTHDR : PH_RAW);
         pix_f = area[27:0]; bip_f = 2'd0; pend_f = 1'b0;
      end
   end

   // final status and result word
   logic [4:0]  fst2;
   logic [95:0] res2;
   always_comb begin
      if (err_f != ST_OK) fst2 = err_f;
      else begin
         unique case (ph_f)
            PH_HEADER: fst2 = ST_SHORT_HDR;
            PH_SKIP:   fst2 = ST_SHORT_SKIP;
            PH_RAW:    fst2 = ST_SHORT_RAW;
            PH_PKTHDR: fst2 = ST_SHORT_PKHDR;
            PH_REPEAT: fst2 = ST_SHORT_REP;
            PH_RAWPKT: fst2 = ST_SHORT_RPKT;
            default:   fst2 = ST_OK;
         endcase
      end
      res2 = (fst2 == ST_OK) ? res : {91'd0, fst2};
   end

   // store header bytes
   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < HEADER_LEN; i++) hdr_ff[i] <= hdr_nx[i];
      end
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; hcnt_ff <= '0; skip_ff <= '0; pix_ff <= '0;
         pkt_ff <= '0; bip_ff <= '0; lowb_ff <= '0; pend_ff <= 1'b0;
         err_ff <= ST_OK;
      end else if (take) begin
         if (req_tlast) begin
            phase_ff <= PH_HEADER; hcnt_ff <= '0; skip_ff <= '0; pix_ff <= '0;
            pkt_ff <= '0; bip_ff <= '0; lowb_ff <= '0; pend_ff <= 1'b0;
            err_ff <= ST_OK;
         end else begin
            phase_ff <= ph_f; hcnt_ff <= (phase_ff == PH_HEADER) ? hcnt_in : hcnt_ff;
            skip_ff <= skip_f; pix_ff <= pix_f; pkt_ff <= pkt_in; bip_ff <= bip_f;
            lowb_ff <= lowb_in; pend_ff <= pend_f; err_ff <= err_f;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (take && req_tlast) ov_ff <= 1'b1;
      else if (rsp_tready) ov_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (take && req_tlast) od_ff <= res2;
   end

   ap_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !(take && req_tlast)) |=> $stable(err_ff))
      else $error("error latch changed");
   ap_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   ap_hcnt: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (hcnt_ff < 5'(HEADER_LEN)))
      else $error("header count overrun");
endmodule
